// ===== sv/eflalloc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, widths and codes of the extent free-list allocator
// no dependencies
package eflalloc_pkg;

  localparam int BLK_W          = 12;
  localparam int VOL_W          = 13;
  localparam int CMD_W          = 2;
  localparam int ST_W           = 2;
  localparam int VOL_CAP        = 4096;
  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int REC_W          = 2 * BLK_W;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [ST_W-1:0]  status_t;
  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [VOL_W-1:0] vol_t;

  localparam cmd_t CMD_INIT  = 2'd0;
  localparam cmd_t CMD_ALLOC = 2'd1;
  localparam cmd_t CMD_FREE  = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOSPACE = 2'd1;
  localparam status_t ST_ILLEGAL = 2'd2;

  localparam vol_t VOL_RESET = 13'd4096;
  localparam vol_t VOL_MIN   = 13'd2;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

// ===== sv/eflalloc_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for request and response words
// depends on eflalloc_pkg
interface eflalloc_req_if import eflalloc_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  command;
  blk_t  block_index;

  modport source (output valid, output command, output block_index, input ready);
  modport sink   (input valid, input command, input block_index, output ready);
endinterface

interface eflalloc_rsp_if import eflalloc_pkg::*; ();
  logic    valid;
  logic    ready;
  blk_t    allocated_block;
  status_t status;
  blk_t    free_count;

  modport source (output valid, output allocated_block, output status, output free_count,
                  input ready);
  modport sink   (input valid, input allocated_block, input status, input free_count,
                  output ready);
endinterface

// ===== sv/eflalloc_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module eflalloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/eflalloc_ctrl.sv =====
`timescale 1ns / 1ps
// controller: takes one request word, runs it, holds the response valid flag
// depends on eflalloc_pkg
module eflalloc_ctrl import eflalloc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait here while the previous response is still unclaimed
        if (slot_free) begin
          cmd.execute = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_exec_gives_word: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> out_valid)
    else $error("executed command left no response word");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.execute)
    else $error("pending response word overwritten");

endmodule

// ===== sv/eflalloc_dp.sv =====
`timescale 1ns / 1ps
// datapath: head, free count, volume register, extent record ram, response payload
// depends on eflalloc_pkg and eflalloc_ram
module eflalloc_dp import eflalloc_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  ctrl_cmd_t cmd,
  input  cmd_t      command,
  input  blk_t      block_index,
  input  logic      cfg_wr_en,
  input  vol_t      cfg_wr_data,
  output blk_t      allocated_block,
  output status_t   status,
  output blk_t      free_count
);

  localparam int MEM_DEPTH = (MAX_BLOCKS < VOL_CAP) ? MAX_BLOCKS : VOL_CAP;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam vol_t VOL_TOP = VOL_W'(MEM_DEPTH);

  function automatic logic idx_ok(input blk_t idx);
    idx_ok = (int'(idx) < MAX_BLOCKS);
  endfunction

  vol_t vol;
  blk_t head;
  blk_t free_cnt;
  cmd_t cmd_q;
  blk_t blk_q;
  logic rd_ok_q;

  logic [REC_W-1:0] rd_data;
  blk_t    rec_run;
  blk_t    rec_link;
  vol_t    v_eff;
  vol_t    v_m1;
  blk_t    head_inc;
  blk_t    head_next;
  blk_t    free_next;
  blk_t    got;
  status_t st;
  logic    wr_req;
  blk_t    wr_idx;
  blk_t    wr_run;
  blk_t    wr_link;
  logic    wr_en;

  // effective volume size, clamped to at least VOL_MIN and to what the record store can hold
  always_comb begin
    if (vol < VOL_MIN) begin
      v_eff = VOL_MIN;
    end else if (vol > VOL_TOP) begin
      v_eff = VOL_TOP;
    end else begin
      v_eff = vol;
    end
  end

  assign v_m1     = v_eff - VOL_W'(1);
  assign head_inc = head + BLK_W'(1);
  assign rec_run  = rd_ok_q ? rd_data[REC_W-1:BLK_W] : '0;
  assign rec_link = rd_ok_q ? rd_data[BLK_W-1:0] : '0;

  always_comb begin
    head_next = head;
    free_next = free_cnt;
    got       = '0;
    st        = ST_OK;
    wr_req    = 1'b0;
    wr_idx    = '0;
    wr_run    = '0;
    wr_link   = '0;
    unique case (cmd_q)
      CMD_INIT: begin
        head_next = BLK_W'(1);
        free_next = v_m1[BLK_W-1:0];
        wr_req    = 1'b1;
        wr_idx    = BLK_W'(1);
        wr_run    = v_m1[BLK_W-1:0];
      end
      CMD_ALLOC: begin
        if (free_cnt == '0 || head == '0) begin
          st = ST_NOSPACE;
        end else begin
          got       = head;
          free_next = free_cnt - BLK_W'(1);
          if (rec_run <= BLK_W'(1)) begin
            // single-block extent is popped
            head_next = rec_link;
          end else begin
            // record moves up one block, one shorter
            head_next = head_inc;
            wr_req    = 1'b1;
            wr_idx    = head_inc;
            wr_run    = rec_run - BLK_W'(1);
            wr_link   = rec_link;
          end
        end
      end
      CMD_FREE: begin
        if (blk_q == '0 || {1'b0, blk_q} >= v_eff || {1'b0, free_cnt} >= v_m1) begin
          st = ST_ILLEGAL;
        end else begin
          head_next = blk_q;
          free_next = free_cnt + BLK_W'(1);
          wr_req    = 1'b1;
          wr_idx    = blk_q;
          wr_run    = BLK_W'(1);
          wr_link   = head;
        end
      end
      default: ;
    endcase
  end

  assign wr_en = cmd.execute && wr_req && idx_ok(wr_idx);

  eflalloc_ram #(
    .WIDTH (REC_W),
    .DEPTH (MEM_DEPTH)
  ) u_rec_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx[AW-1:0]),
    .wdata ({wr_run, wr_link}),
    .re    (cmd.capture),
    .raddr (head[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vol      <= VOL_RESET;
      head     <= '0;
      free_cnt <= '0;
    end else begin
      if (cfg_wr_en) begin
        vol <= cfg_wr_data;
      end
      if (cmd.execute) begin
        head     <= head_next;
        free_cnt <= free_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q   <= command;
      blk_q   <= block_index;
      rd_ok_q <= idx_ok(head);
    end
    if (cmd.execute) begin
      allocated_block <= got;
      status          <= st;
      free_count      <= free_next;
    end
  end

endmodule

// ===== sv/extent_free_list_allocator_core.sv =====
`timescale 1ns / 1ps
// extent free-list block allocator, top level
// depends on eflalloc_pkg, eflalloc_if, eflalloc_ctrl, eflalloc_dp, eflalloc_ram
// a request word accepted in idle is captured with the read of the head record; exec then
//   commits it once the response slot is free, registering the response word
// a new request is taken only after the current one is committed: the synchronous read of
//   the head record is followed by the exec update that writes the shortened record back
// a waiting response word stalls the exec update and so the acceptance of the next request
// reset (rst, synchronous): empty list, head 0, free count 0, volume 4096; the record
//   store is not cleared and only its entries built by init, alloc or free are used
module extent_free_list_allocator_core import eflalloc_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  eflalloc_req_if.sink request,
  eflalloc_rsp_if.source response,
  input  logic         cfg_wr_en,
  input  vol_t         cfg_wr_data
);

  // command strobes from controller to datapath
  ctrl_cmd_t cmd;

  // controller: idle accepts a word, exec waits for the response slot and commits
  eflalloc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .cmd       (cmd)
  );

  // datapath: list head, free count, volume size, record ram and response payload
  eflalloc_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .command         (request.command),
    .block_index     (request.block_index),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .allocated_block (response.allocated_block),
    .status          (response.status),
    .free_count      (response.free_count)
  );

endmodule
